// File: rtl/rc4s_pkg.sv
// Shared types and constants for the small RC4 stream cipher.
`timescale 1ns / 1ps
`default_nettype none

package rc4s_pkg;

  // Permutation size; must stay a power of two so index sums wrap by truncation
  localparam int STATE_SIZE = 8;
  localparam int IDX_W      = $clog2(STATE_SIZE);

  // Key: KEY_LEN nibbles packed in one register
  localparam int KEY_LEN    = 7;
  localparam int NIB_W      = 4;
  localparam int KEY_W      = KEY_LEN * NIB_W;
  localparam int KPOS_W     = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

  // Field widths
  localparam int DATA_W     = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam int REG_KEY    = 0;

  // Work queue between front and core
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Operation codes for queued work
  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_REKEY  = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data_in;
    logic              first;
  } rc4s_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [IDX_W-1:0]  keystream;
  } rc4s_out_t;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] data;
  } rc4s_item_t;

endpackage

`default_nettype wire

// File: rtl/rc4s_front.sv
// Input stage: takes beats, tags each as rekey or stream work, pushes to the queue.
`timescale 1ns / 1ps
`default_nettype none

module rc4s_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rc4s_pkg::rc4s_in_t   in_data,
  output logic                      q_push,
  output rc4s_pkg::rc4s_item_t      q_item,
  input  wire logic                 q_full
);

  logic                  f_valid_r, f_valid_nxt;
  rc4s_pkg::rc4s_item_t  f_item_r;
  logic                  in_acc;

  // Hold the beat only while the queue is full
  assign in_stall = f_valid_r && q_full;
  assign in_acc   = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_full;
  assign q_item   = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_acc) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // Classify: first-of-message beats carry a rekey
  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_item_r.op   <= in_data.first ? rc4s_pkg::OP_REKEY : rc4s_pkg::OP_STREAM;
      f_item_r.data <= in_data.data_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rc4s_queue.sv
// Short FIFO of tagged work between the front stage and the cipher core.
`timescale 1ns / 1ps
`default_nettype none

module rc4s_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire rc4s_pkg::rc4s_item_t  push_item,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       q_valid,
  output rc4s_pkg::rc4s_item_t       q_item
);

  rc4s_pkg::rc4s_item_t              slot_r [rc4s_pkg::QDEPTH];
  logic [rc4s_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [rc4s_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign full    = (cnt_r == rc4s_pkg::QCNT_W'(rc4s_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == rc4s_pkg::QPTR_W'(rc4s_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == rc4s_pkg::QPTR_W'(rc4s_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rc4s_core.sv
// Cipher core: key schedule and generator sequencer over the permutation memory.
`timescale 1ns / 1ps
`default_nettype none

module rc4s_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire rc4s_pkg::rc4s_item_t       q_item,
  output logic                            q_pop,
  input  wire logic [rc4s_pkg::KEY_W-1:0] key,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rc4s_pkg::rc4s_out_t             out_data
);

  localparam int IW = rc4s_pkg::IDX_W;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_G0   = 4'd1;
  localparam logic [3:0] ST_G1   = 4'd2;
  localparam logic [3:0] ST_G2   = 4'd3;
  localparam logic [3:0] ST_G3   = 4'd4;
  localparam logic [3:0] ST_K0   = 4'd5;
  localparam logic [3:0] ST_K1   = 4'd6;
  localparam logic [3:0] ST_K2   = 4'd7;
  localparam logic [3:0] ST_K3   = 4'd8;

  localparam logic [IW-1:0] IDX_LAST = IW'(rc4s_pkg::STATE_SIZE - 1);
  localparam logic [rc4s_pkg::KPOS_W-1:0] KPOS_LAST =
    rc4s_pkg::KPOS_W'(rc4s_pkg::KEY_LEN - 1);

  logic [3:0]                      state_r, state_nxt;
  logic [IW-1:0]                   gen_r, gen_nxt;
  logic [IW-1:0]                   mix_r, mix_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [IW-1:0]                   jn_r, jn_nxt;
  logic [IW-1:0]                   si_r, si_nxt;
  logic [IW-1:0]                   sj_r, sj_nxt;
  logic [IW-1:0]                   t_r, t_nxt;
  logic [rc4s_pkg::KPOS_W-1:0]     kpos_r, kpos_nxt;
  logic [rc4s_pkg::DATA_W-1:0]     data_r, data_nxt;
  logic                            out_valid_r, out_valid_nxt;
  rc4s_pkg::rc4s_out_t             out_data_r;

  // Permutation memory: one write and one registered read a cycle.
  // Entries not yet written since the last rekey read as their own index.
  logic [IW-1:0]                   perm_mem [rc4s_pkg::STATE_SIZE];
  logic [rc4s_pkg::STATE_SIZE-1:0] vld_r;
  logic [IW-1:0]                   rd_q, rd_addr_q, rd_addr, rd_data;
  logic                            rd_vld_q;
  logic                            we;
  logic [IW-1:0]                   wa, wd;
  logic                            vld_clr;

  logic                            out_free, load_out;
  logic [IW-1:0]                   ks;
  logic [rc4s_pkg::NIB_W-1:0]      key_nib;

  assign rd_data  = rd_vld_q ? rd_q : rd_addr_q;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid && out_free;
  assign key_nib  = key[kpos_r * rc4s_pkg::NIB_W +: rc4s_pkg::NIB_W];

  // Keystream after the swap: forward the two swapped entries
  always_comb begin
    if (t_r == idx_r) begin
      ks = sj_r;
    end else if (t_r == jn_r) begin
      ks = si_r;
    end else begin
      ks = rd_data;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    mix_nxt   = mix_r;
    idx_nxt   = idx_r;
    jn_nxt    = jn_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    t_nxt     = t_r;
    kpos_nxt  = kpos_r;
    data_nxt  = data_r;
    rd_addr   = idx_r;
    we        = 1'b0;
    wa        = idx_r;
    wd        = rd_data;
    vld_clr   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = gen_r + 1'b1;
        if (q_pop) begin
          data_nxt = q_item.data;
          if (q_item.op == rc4s_pkg::OP_REKEY) begin
            vld_clr   = 1'b1;
            mix_nxt   = '0;
            idx_nxt   = '0;
            kpos_nxt  = '0;
            state_nxt = ST_K0;
          end else begin
            gen_nxt   = gen_r + 1'b1;
            idx_nxt   = gen_r + 1'b1;
            state_nxt = ST_G1;
          end
        end
      end
      ST_G0: begin
        rd_addr   = idx_r;
        state_nxt = ST_G1;
      end
      ST_G1: begin
        si_nxt    = rd_data;
        jn_nxt    = mix_r + rd_data;
        mix_nxt   = mix_r + rd_data;
        rd_addr   = mix_r + rd_data;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        we        = 1'b1;
        wa        = idx_r;
        wd        = rd_data;
        sj_nxt    = rd_data;
        t_nxt     = si_r + rd_data;
        rd_addr   = si_r + rd_data;
        state_nxt = ST_G3;
      end
      ST_G3: begin
        we        = 1'b1;
        wa        = jn_r;
        wd        = si_r;
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_K0: begin
        rd_addr   = idx_r;
        state_nxt = ST_K1;
      end
      ST_K1: begin
        si_nxt    = rd_data;
        jn_nxt    = mix_r + rd_data + key_nib[IW-1:0];
        mix_nxt   = mix_r + rd_data + key_nib[IW-1:0];
        rd_addr   = mix_r + rd_data + key_nib[IW-1:0];
        state_nxt = ST_K2;
      end
      ST_K2: begin
        we        = 1'b1;
        wa        = idx_r;
        wd        = rd_data;
        state_nxt = ST_K3;
      end
      ST_K3: begin
        we = 1'b1;
        wa = jn_r;
        wd = si_r;
        if (idx_r == IDX_LAST) begin
          // Schedule done: indices restart, element then runs the generator
          mix_nxt   = '0;
          gen_nxt   = IW'(1);
          idx_nxt   = IW'(1);
          state_nxt = ST_G0;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          kpos_nxt  = (kpos_r == KPOS_LAST) ? '0 : kpos_r + 1'b1;
          state_nxt = ST_K0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_r       <= '0;
      mix_r       <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      mix_r       <= mix_nxt;
      out_valid_r <= out_valid_nxt;
      if (vld_clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[wa] <= 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    jn_r   <= jn_nxt;
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    kpos_r <= kpos_nxt;
    data_r <= data_nxt;
    if (load_out) begin
      out_data_r.data_out  <= data_r ^ rc4s_pkg::DATA_W'(ks);
      out_data_r.keystream <= ks;
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      perm_mem[wa] <= wd;
    end
    rd_q      <= perm_mem[rd_addr];
    rd_addr_q <= rd_addr;
    rd_vld_q  <= vld_r[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/small_rc4_stream_cipher.sv
// Top level of the small RC4 stream cipher: register port and stage wiring.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one 4-bit element
//   per beat; in_data.first marks the first element of a message and makes
//   the block rerun the key schedule and clear both indices first.
//   Result channel (out_valid / out_stall / out_data) returns exactly one
//   beat per input beat, in order: data XOR keystream, and the keystream.
//   Key nibbles sit in the register at byte address 0 of the cfg_ port;
//   a new key is used from the next first-of-message element on.
// Sequencing:
//   An element passes through the generator sequencer states in turn (read, read,
//   swap write, swap write into the single-write permutation memory), and
//   the core takes the next element only once the last one is done. A
//   first-of-message element runs the key schedule over every entry first.
// Reset: the permutation returns to identity, indices and key to zero.
// A stalled receiver holds the result register; the front stage and a
// two-entry queue keep taking input beats until they fill.
`timescale 1ns / 1ps
`default_nettype none

module small_rc4_stream_cipher (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire rc4s_pkg::rc4s_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output rc4s_pkg::rc4s_out_t                   out_data,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [rc4s_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [rc4s_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rc4s_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  logic [rc4s_pkg::KEY_W-1:0] key_r;
  logic                       cfg_wr;
  logic                       sel_key;
  logic                       push, q_full, q_valid, q_pop;
  rc4s_pkg::rc4s_item_t       push_item, q_item;

  // Register decode: word index from the address above the byte offset
  assign cfg_pready = 1'b1;
  assign sel_key    = (cfg_paddr[rc4s_pkg::CFG_ADDR_W-1:2] ==
                       (rc4s_pkg::CFG_ADDR_W - 2)'(rc4s_pkg::REG_KEY));
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr && sel_key) begin
      key_r <= cfg_pwdata[rc4s_pkg::KEY_W-1:0];
    end
  end

  assign cfg_prdata = sel_key ? rc4s_pkg::CFG_DATA_W'(key_r) : '0;

  rc4s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (push),
    .q_item   (push_item),
    .q_full   (q_full)
  );

  rc4s_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rc4s_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .key       (key_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/rc4s_checker.sv
// Port-level checks for the small RC4 stream cipher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rc4s_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire rc4s_pkg::rc4s_out_t  out_data
);

  // Items in flight: front stage, queue, and one beat in the core or the
  // result register (the core only starts once the result register drains)
  localparam int MAX_PEND = rc4s_pkg::QDEPTH + 2;

  logic [3:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_acc) - 4'(out_acc);
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // No result without an outstanding input
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result beat with no item outstanding");

  // Input back-pressure once every buffer is full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 4'(MAX_PEND) |-> in_stall)
    else $error("input taken beyond buffer capacity");

  // Reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind small_rc4_stream_cipher rc4s_checker u_rc4s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: test/small_rc4_stream_cipher_tb.sv
// Self-checking testbench for the small RC4 stream cipher: directed and random message traffic.
`timescale 1ns / 1ps

module small_rc4_stream_cipher_tb;
  import rc4s_pkg::*;

  // Register map: one key register, the next slot is unmapped
  localparam int REG_UNMAPPED = REG_KEY + 1;
  localparam logic [CFG_ADDR_W-1:0] KEY_ADDR      = CFG_ADDR_W'(4 * REG_KEY);
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = CFG_ADDR_W'(4 * REG_UNMAPPED);

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_BEATS = 1300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rc4s_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  rc4s_out_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Cipher state as the block should hold it
  logic [IDX_W-1:0] perm_model [STATE_SIZE];
  logic [IDX_W-1:0] gen_model;
  logic [IDX_W-1:0] mix_model;
  logic [KEY_W-1:0] key_model;

  rc4s_out_t cipher_q [$];

  int error_count;
  int beats_sent;
  int beats_checked;
  int rekeys_sent;
  int key_writes;
  int burst_left;
  int stall_mode;
  int stall_left;
  int cycle_count;

  small_rc4_stream_cipher u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Mismatch reporting
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Key schedule: identity table, then the mixing pass, indices cleared
  function automatic void rekey_model();
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] t;
    logic [NIB_W-1:0] nib;
    for (int i = 0; i < STATE_SIZE; i++) perm_model[i] = IDX_W'(i);
    j = '0;
    for (int i = 0; i < STATE_SIZE; i++) begin
      nib = key_model[NIB_W * (i % KEY_LEN) +: NIB_W];
      j = IDX_W'(j + perm_model[i] + nib);
      t = perm_model[i];
      perm_model[i] = perm_model[j];
      perm_model[j] = t;
    end
    gen_model = '0;
    mix_model = '0;
  endfunction

  // One generator step and the XOR with the data element
  function automatic rc4s_out_t cipher_step(input logic [DATA_W-1:0] d, input logic f);
    rc4s_out_t        r;
    logic [IDX_W-1:0] t;
    logic [IDX_W-1:0] ks;
    if (f) rekey_model();
    gen_model = gen_model + 1'b1;
    mix_model = mix_model + perm_model[gen_model];
    t = perm_model[gen_model];
    perm_model[gen_model] = perm_model[mix_model];
    perm_model[mix_model] = t;
    ks = perm_model[IDX_W'(perm_model[gen_model] + perm_model[mix_model])];
    r.data_out  = d ^ {1'b0, ks};
    r.keystream = ks;
    return r;
  endfunction

  // Receiver stall pattern: the mode is redrawn whenever the stall countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= (cycle_count % 3 == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    rc4s_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected result beat", out_data, 0);
      end else begin
        want = cipher_q.pop_front();
        if (out_data.data_out !== want.data_out)
          report_mismatch("data_out", out_data.data_out, want.data_out);
        if (out_data.keystream !== want.keystream)
          report_mismatch("keystream", out_data.keystream, want.keystream);
        beats_checked++;
      end
    end
  end

  // Send one beat; the sender works in bursts with random gaps
  task automatic send_beat(input logic [DATA_W-1:0] d, input logic f);
    rc4s_in_t beat;
    int       gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    beat.data_in = d;
    beat.first   = f;
    in_valid <= 1'b1;
    in_data  <= beat;
    cipher_q.push_back(cipher_step(d, f));
    beats_sent++;
    if (f) rekeys_sent++;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Hold off until every expected result has come back
  task automatic wait_for_drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup phase then access phase, then the bus returns to idle
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == KEY_ADDR) key_model = data[KEY_W-1:0];
    key_writes++;
    @(posedge clk);
  endtask

  // Register read of the key, compared on its defined bits
  task automatic check_key_readback();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= KEY_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[KEY_W-1:0] !== key_model)
      report_mismatch("key readback", cfg_prdata[KEY_W-1:0], key_model);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Streaming straight after reset runs on the identity table
  task automatic test_unkeyed_stream();
    send_beat(4'h0, 1'b0);
    send_beat(4'hF, 1'b0);
    send_beat(4'h5, 1'b0);
    send_beat(4'hA, 1'b0);
    wait_for_drain();
  endtask

  // All-zero and all-ones keys
  task automatic test_key_extremes();
    reg_write(KEY_ADDR, '0);
    check_key_readback();
    send_beat(4'hF, 1'b1);
    send_beat(4'h0, 1'b0);
    send_beat(4'h9, 1'b0);
    wait_for_drain();
    reg_write(KEY_ADDR, {{(CFG_DATA_W-KEY_W){1'b0}}, {KEY_W{1'b1}}});
    check_key_readback();
    send_beat(4'h0, 1'b1);
    send_beat(4'hF, 1'b0);
    send_beat(4'h6, 1'b0);
    wait_for_drain();
  endtask

  // A new key only bites at the next first-of-message beat
  task automatic test_deferred_rekey();
    reg_write(KEY_ADDR, 32'h0123_4567);
    send_beat(4'h3, 1'b0);
    send_beat(4'hC, 1'b0);
    send_beat(4'h7, 1'b1);
    send_beat(4'h8, 1'b0);
    wait_for_drain();
  endtask

  // Unmapped register and bits above the key width are ignored
  task automatic test_register_decode();
    reg_write(KEY_ADDR, 32'h0765_4321);
    reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    check_key_readback();
    reg_write(KEY_ADDR, 32'hF000_0000 | 32'h0A5C_3E1B);
    check_key_readback();
    send_beat(4'h1, 1'b1);
    send_beat(4'hE, 1'b0);
    send_beat(4'h4, 1'b0);
    wait_for_drain();
  endtask

  // Random messages over several keys, with some broken-off streams
  task automatic test_random_traffic(input int n_beats);
    int sent;
    int msg_len;
    int phase_len;
    int phase;
    logic [CFG_DATA_W-1:0] key_val;
    sent  = 0;
    phase = 0;
    while (sent < n_beats) begin
      // new key per phase, extremes included
      case (phase % 5)
        0: key_val = '0;
        1: key_val = {{(CFG_DATA_W-KEY_W){1'b0}}, {KEY_W{1'b1}}};
        default: key_val = $urandom();
      endcase
      reg_write(KEY_ADDR, key_val);
      phase_len = $urandom_range(100, 220);
      while (phase_len > 0 && sent < n_beats) begin
        // mostly well-formed messages, sometimes a stream with no rekey
        msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        for (int k = 0; k < msg_len; k++) begin
          send_beat(4'($urandom_range(0, 15)),
                    (k == 0) && ($urandom_range(0, 9) != 0));
          sent++;
          phase_len--;
        end
        // occasional full drain mid-phase
        if ($urandom_range(0, 24) == 0) wait_for_drain();
      end
      wait_for_drain();
      phase++;
    end
  endtask

  // Cycle limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, cipher_q.size());
    $display("Mismatches found");
    $finish;
  end

  // Test sequence
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    error_count   = 0;
    beats_sent    = 0;
    beats_checked = 0;
    rekeys_sent   = 0;
    key_writes    = 0;
    burst_left    = 0;
    stall_mode    = 0;
    stall_left    = 0;
    cycle_count   = 0;
    key_model     = '0;
    for (int i = 0; i < STATE_SIZE; i++) perm_model[i] = IDX_W'(i);
    gen_model = '0;
    mix_model = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_unkeyed_stream();
    test_key_extremes();
    test_deferred_rekey();
    test_register_decode();
    test_random_traffic(RANDOM_BEATS);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d beats (%0d rekeys) and %0d register writes;",
             beats_sent, rekeys_sent, key_writes);
    $display("%0d result beats compared under random sender gaps and receiver stalls.",
             beats_checked);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
